// ===== sv/fwn_pkg.sv =====
// ----------------------------------------------------------------------------
// fwn_pkg
// Types, constants and match functions shared by the full-width normalizer.
// ----------------------------------------------------------------------------
package fwn_pkg;

	localparam logic [15:0] FW_FIRST  = 16'hFF01;
	localparam logic [15:0] FW_LAST   = 16'hFF5E;
	localparam logic [15:0] FW_OFFSET = 16'hFEE0;

	localparam logic [7:0] LEAD_C3   = 8'hC3;
	localparam logic [7:0] LEAD_E2   = 8'hE2;
	localparam logic [7:0] LEAD_E3   = 8'hE3;
	localparam logic [7:0] LEAD_EF   = 8'hEF;
	localparam logic [7:0] MASK_HI4  = 8'hF0;
	localparam logic [7:0] LEAD_3B   = 8'hE0;
	localparam logic [7:0] MASK_CONT = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	localparam logic [7:0] SEQ_MUL   = 8'h97;
	localparam logic [7:0] SEQ_DIV   = 8'hB7;
	localparam logic [7:0] SEQ_80    = 8'h80;
	localparam logic [7:0] SEQ_82    = 8'h82;
	localparam logic [7:0] SEQ_83    = 8'h83;
	localparam logic [7:0] SEQ_BC    = 8'hBC;
	localparam logic [7:0] SEQ_BD    = 8'hBD;
	localparam logic [7:0] SEQ_88    = 8'h88;
	localparam logic [7:0] SEQ_92    = 8'h92;

	localparam logic [7:0] ASC_SPACE = 8'h20;
	localparam logic [7:0] ASC_STAR  = 8'h2A;
	localparam logic [7:0] ASC_DASH  = 8'h2D;
	localparam logic [7:0] ASC_DOT   = 8'h2E;
	localparam logic [7:0] ASC_SLASH = 8'h2F;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [1:0]      cnt;
		item_t [2:0]     item;
	} push_t;

	typedef struct packed {
		logic [1:0]       res_cnt;
		item_t [2:0]      res;
		logic [1:0]       hold_cnt;
		logic [1:0][7:0]  hold_byte;
	} scan_res_t;

	typedef struct packed {
		logic [1:0] len;
		logic [7:0] rep;
	} match_t;

	// complete match at b0.. with rem bytes available
	function automatic match_t match_at(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
		logic [1:0] rem);
		match_t     m;
		logic [15:0] cp;
		logic [15:0] diff;
		m    = '0;
		cp   = {b0[3:0], b1[5:0], b2[5:0]};
		diff = cp - FW_OFFSET;
		if (rem >= 2'd2 && b0 == LEAD_C3 && b1 == SEQ_MUL) begin
			m = '{len: 2'd2, rep: ASC_STAR};
		end else if (rem >= 2'd2 && b0 == LEAD_C3 && b1 == SEQ_DIV) begin
			m = '{len: 2'd2, rep: ASC_SLASH};
		end else if (rem == 2'd3) begin
			if (b0 == LEAD_E3 && b1 == SEQ_80 && b2 == SEQ_80) begin
				m = '{len: 2'd3, rep: ASC_SPACE};
			end else if (b0 == LEAD_E3 && b1 == SEQ_83 && b2 == SEQ_BC) begin
				m = '{len: 2'd3, rep: ASC_DASH};
			end else if (b0 == LEAD_E2 && b1 == SEQ_88 && b2 == SEQ_92) begin
				m = '{len: 2'd3, rep: ASC_DASH};
			end else if (b0 == LEAD_E3 && b1 == SEQ_80 && b2 == SEQ_82) begin
				m = '{len: 2'd3, rep: ASC_DOT};
			end else if ((b0 & MASK_HI4) == LEAD_3B && (b1 & MASK_CONT) == CONT_TAG
				&& (b2 & MASK_CONT) == CONT_TAG && cp >= FW_FIRST && cp <= FW_LAST) begin
				m = '{len: 2'd3, rep: diff[7:0]};
			end
		end
		return m;
	endfunction

	// b0.. (rem bytes) is a proper prefix of some match
	function automatic logic may_grow(logic [7:0] b0, logic [7:0] b1, logic [1:0] rem);
		logic g;
		g = 1'b0;
		if (rem == 2'd1) begin
			g = (b0 == LEAD_C3) || (b0 == LEAD_E3) || (b0 == LEAD_E2) || (b0 == LEAD_EF);
		end else if (rem == 2'd2) begin
			g = (b0 == LEAD_E3 && (b1 == SEQ_80 || b1 == SEQ_83))
				|| (b0 == LEAD_E2 && b1 == SEQ_88)
				|| (b0 == LEAD_EF && (b1 == SEQ_BC || b1 == SEQ_BD));
		end
		return g;
	endfunction

endpackage

// ===== sv/fwn_scan.sv =====
// ----------------------------------------------------------------------------
// fwn_scan
// Scans held bytes plus the new byte, emits up to three result bytes.
// ----------------------------------------------------------------------------
module fwn_scan (
	input  logic [1:0]       held_cnt,
	input  logic [1:0][7:0]  held_byte,
	input  logic [7:0]       cur_byte,
	input  logic             cur_last,
	output fwn_pkg::scan_res_t res
);

	logic [7:0]       b [5];
	logic [1:0]       n;
	logic [1:0]       pos;
	logic [1:0]       k;
	logic             stop;
	logic [1:0]       rem;
	logic [2:0]       idx;
	fwn_pkg::match_t  m;

	always_comb begin
		b[0] = '0;
		b[1] = '0;
		b[2] = '0;
		b[3] = '0;
		b[4] = '0;
		case (held_cnt)
			2'd0: begin
				b[0] = cur_byte;
			end
			2'd1: begin
				b[0] = held_byte[0];
				b[1] = cur_byte;
			end
			default: begin
				b[0] = held_byte[0];
				b[1] = held_byte[1];
				b[2] = cur_byte;
			end
		endcase
		n    = (held_cnt == 2'd2) ? 2'd3 : held_cnt + 2'd1;
		pos  = '0;
		k    = '0;
		stop = 1'b0;
		rem  = '0;
		idx  = '0;
		m    = '0;
		res  = '0;
		for (int it = 0; it < 3; it++) begin
			if (!stop && pos < n) begin
				rem = n - pos;
				idx = {1'b0, pos};
				m   = fwn_pkg::match_at(b[idx], b[idx + 3'd1], b[idx + 3'd2], rem);
				if (m.len != 2'd0) begin
					res.res[k].data = m.rep;
					res.res[k].last = cur_last && (pos + m.len == n);
					k   = k + 2'd1;
					pos = pos + m.len;
				end else if (!cur_last && fwn_pkg::may_grow(b[idx], b[idx + 3'd1], rem)) begin
					stop = 1'b1;
				end else begin
					res.res[k].data = b[idx];
					res.res[k].last = cur_last && (pos + 2'd1 == n);
					k   = k + 2'd1;
					pos = pos + 2'd1;
				end
			end
		end
		idx              = {1'b0, pos};
		res.res_cnt      = k;
		res.hold_cnt     = n - pos;
		res.hold_byte[0] = b[idx];
		res.hold_byte[1] = b[idx + 3'd1];
	end

endmodule

// ===== sv/fwn_queue.sv =====
// ----------------------------------------------------------------------------
// fwn_queue
// Result queue: takes up to three items per cycle, hands out one per cycle while q_ready is high.
// ----------------------------------------------------------------------------
module fwn_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fwn_pkg::push_t   push,
	output logic             room,
	output logic             q_valid,
	input  logic             q_ready,
	output fwn_pkg::item_t   q_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fwn_pkg::item_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   widx [3];
	logic [PW-1:0]   wr_next;
	logic            pop;
	int unsigned     sum;

	assign pop     = q_valid && q_ready;
	assign q_valid = (count_q != '0);
	assign q_item  = mem_q[rd_ptr_q];
	assign room    = (count_q <= CW'(DEPTH - 3));

	always_comb begin
		sum = 0;
		for (int j = 0; j < 3; j++) begin
			sum = int'(wr_ptr_q) + j;
			if (sum >= DEPTH) begin
				sum = sum - DEPTH;
			end
			widx[j] = PW'(sum);
		end
		sum = int'(wr_ptr_q) + int'(push.cnt);
		if (sum >= DEPTH) begin
			sum = sum - DEPTH;
		end
		wr_next = PW'(sum);
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			if (int'(push.cnt) > j) begin
				mem_q[widx[j]] <= push.item[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_next;
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

endmodule

// ===== sv/fullwidth_utf8_to_ascii_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// fullwidth_utf8_to_ascii_normalizer_core
// UTF-8 byte stream normalizer: full-width ASCII and a few symbols to ASCII.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid / in_ready   | in_byte, in_last
//  out     | out_valid / out_ready | out_byte, out_last
//
// One input transaction per cycle while in_ready is high; a byte is held in
// the input register, scanned and put in the result queue (QUEUE_DEPTH entries).
// Input is taken while the queue has room for three results.
// Reset clears the held-byte count and the queue; held bytes are not cleared.
// Output stalls back up through the queue into the input register.
// ----------------------------------------------------------------------------
module fullwidth_utf8_to_ascii_normalizer_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic                v_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic [1:0]          held_cnt_q;
	logic [1:0][7:0]     held_byte_q;
	logic                room;
	logic                adv;
	fwn_pkg::scan_res_t  scan;
	fwn_pkg::push_t      push;
	fwn_pkg::item_t      q_item;

	assign adv      = v_s1 && room;
	assign in_ready = !v_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
		if (adv) begin
			held_byte_q <= scan.hold_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
		end else if (adv) begin
			held_cnt_q <= scan.hold_cnt;
		end
	end

	fwn_scan u_scan (
		.held_cnt  (held_cnt_q),
		.held_byte (held_byte_q),
		.cur_byte  (byte_s1),
		.cur_last  (last_s1),
		.res       (scan)
	);

	always_comb begin
		push.item = scan.res;
		push.cnt  = adv ? scan.res_cnt : 2'd0;
	end

	fwn_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.q_valid (out_valid),
		.q_ready (out_ready),
		.q_item  (q_item)
	);

	assign out_byte = q_item.data;
	assign out_last = q_item.last;

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q != 2'd3)
		else $error("held byte count out of range");

	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |-> scan.res_cnt != 2'd0 && scan.hold_cnt == 2'd0)
		else $error("end of string left bytes held or gave no result");

	a_result_seen: assert property (@(posedge clk) disable iff (!arst_n)
		adv && scan.res_cnt != 2'd0 |=> out_valid)
		else $error("scanned result did not reach the output");

endmodule
